>>> rtl/wvadsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wvadsr_pkg
// Shared widths, codes and state encoding of the wavetable voice.
// ---------------------------------------------------------------------------
package wvadsr_pkg;

	localparam int TABLE_SIZE  = 2048;
	localparam int ADDR_BITS   = $clog2(TABLE_SIZE);
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 24;
	localparam int PHASE_BITS  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int GAIN_BITS   = 17;
	localparam int CFG_BITS    = 32;
	localparam int CFG_IDX_BITS = 3;
	localparam int NUM_BITS    = GAIN_BITS + COUNT_BITS;
	localparam int REM_BITS    = COUNT_BITS + 1;
	localparam int STEP_BITS   = $clog2(FRAC_BITS + 1);
	localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(65536);

	// input item modes
	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_START = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PHASE_STEP  = 3'd0,
		REG_ATTACK_LEN  = 3'd1,
		REG_DECAY_LEN   = 3'd2,
		REG_RELEASE_LEN = 3'd3,
		REG_NOTE_LEN    = 3'd4,
		REG_SUSTAIN     = 3'd5
	} reg_idx_t;

	// envelope segment
	typedef enum logic [1:0] {
		SEG_ATTACK  = 2'd0,
		SEG_DECAY   = 2'd1,
		SEG_RELEASE = 2'd2,
		SEG_SUSTAIN = 2'd3
	} seg_t;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RD0   = 7'b0000010,
		ST_RD1   = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

>>> rtl/wavetable_voice_with_adsr.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wavetable_voice_with_adsr
// One-voice wavetable oscillator with linear interpolation and ADSR envelope.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries items with a mode:
// table write, note start, or tick. Table writes and note starts are taken
// while idle and give no result. A tick gives one result item on the output
// channel (out_valid / out_stall): the envelope-scaled sample, a flag on the
// last sample of the note and a flag for ticks after the note has ended.
// A tick inside a note passes from acceptance to out_valid through two
// table reads on the single read port, the products, a 16-step bit-serial
// restoring divider for the envelope ramp, the scaling multiply and the
// output load. A tick past the note end goes from idle straight to output
// load. in_stall is high while a tick is in work, so one item is taken at
// a time. The output register holds a result until it is taken; while the
// receiver stalls, a new tick finishes its work and then waits to load it.
// Configuration writes go through cfg_write / cfg_index / cfg_data; the user
// must make them only while the block is idle, which it does not enforce.
// Reset clears phase, sample count and registers (sustain to unity), counts
// the note as finished; the table is undefined until software loads it.
// ---------------------------------------------------------------------------
module wavetable_voice_with_adsr (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [wvadsr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [wvadsr_pkg::CFG_BITS-1:0]        cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [1:0]                             mode,
	input  wire logic [10:0]                            table_index,
	input  wire logic signed [wvadsr_pkg::SAMPLE_BITS-1:0] table_word,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [wvadsr_pkg::SAMPLE_BITS-1:0]   audio_sample,
	output logic                                        last_of_note,
	output logic                                        past_end
);

	localparam int AW = wvadsr_pkg::ADDR_BITS;
	localparam int SW = wvadsr_pkg::SAMPLE_BITS;
	localparam int CW = wvadsr_pkg::COUNT_BITS;
	localparam int PW = wvadsr_pkg::PHASE_BITS;
	localparam int FW = wvadsr_pkg::FRAC_BITS;
	localparam int GW = wvadsr_pkg::GAIN_BITS;
	localparam int NW = wvadsr_pkg::NUM_BITS;
	localparam int RW = wvadsr_pkg::REM_BITS;
	localparam int TW = wvadsr_pkg::STEP_BITS;

	// configuration registers
	logic [PW-1:0] phase_step_q;
	logic [CW-1:0] attack_len_q, decay_len_q, release_len_q, note_len_q;
	logic [GW-1:0] sustain_q;

	// voice state
	logic [PW-1:0] phase_acc_q;
	logic [CW-1:0] count_q;
	wvadsr_pkg::state_t state_q;

	// work registers
	logic [SW-1:0]         mem [wvadsr_pkg::TABLE_SIZE];
	logic signed [SW-1:0]  rdata_q, s0_q;
	wvadsr_pkg::seg_t      seg_q;
	logic [GW-1:0]         mul_m_q;
	logic [CW-1:0]         mul_k_q, den_q;
	logic                  last_q, pe_q;
	logic signed [SW+FW+1:0] dprod_q;
	logic [NW-1:0]         nprod_q;
	logic [RW-1:0]         rem_q;
	logic [FW-1:0]         qsh_q;
	logic [TW-1:0]         step_q;
	logic signed [SW:0]    s_q;
	logic signed [SW+GW+1:0] yprod_q;
	logic signed [SW-1:0]  audio_q;
	logic                  out_valid_q, last_out_q, pe_out_q;

	logic accept, tick, note_done, out_free;
	logic [AW-1:0] i0, i1, raddr;
	logic [RW-1:0] trial;
	logic          fits;
	logic [GW-1:0] env;
	logic signed [SW+2:0] y_sh;
	logic signed [SW-1:0] y_sat;

	assign accept    = in_valid && !in_stall;
	assign tick      = accept && (wvadsr_pkg::mode_t'(mode) == wvadsr_pkg::MODE_TICK);
	assign note_done = count_q >= note_len_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != wvadsr_pkg::ST_IDLE;

	// table position from the phase accumulator
	assign i0    = phase_acc_q[PW-1 -: AW];
	assign i1    = i0 + AW'(1);
	assign raddr = (state_q == wvadsr_pkg::ST_RD1) ? i1 : i0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= '0;
			attack_len_q  <= '0;
			decay_len_q   <= '0;
			release_len_q <= '0;
			note_len_q    <= '0;
			sustain_q     <= wvadsr_pkg::UNITY;
		end else if (cfg_write) begin
			case (wvadsr_pkg::reg_idx_t'(cfg_index))
				wvadsr_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_data;
				wvadsr_pkg::REG_ATTACK_LEN:  attack_len_q  <= cfg_data[CW-1:0];
				wvadsr_pkg::REG_DECAY_LEN:   decay_len_q   <= cfg_data[CW-1:0];
				wvadsr_pkg::REG_RELEASE_LEN: release_len_q <= cfg_data[CW-1:0];
				wvadsr_pkg::REG_NOTE_LEN:    note_len_q    <= cfg_data[CW-1:0];
				wvadsr_pkg::REG_SUSTAIN: begin
					sustain_q <= (cfg_data[GW-1:0] > wvadsr_pkg::UNITY) ?
						wvadsr_pkg::UNITY : cfg_data[GW-1:0];
				end
				default: ;
			endcase
		end
	end

	// wave table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (accept && wvadsr_pkg::mode_t'(mode) == wvadsr_pkg::MODE_WRITE) begin
			mem[table_index[AW-1:0]] <= table_word;
		end
		rdata_q <= mem[raddr];
	end

	// divider step: shift in the next numerator bit and try the subtract
	assign trial = {rem_q[RW-2:0], qsh_q[FW-1]};
	assign fits  = trial >= RW'(den_q);

	// envelope from the quotient
	always_comb begin
		case (seg_q)
			wvadsr_pkg::SEG_DECAY:   env = wvadsr_pkg::UNITY - GW'(qsh_q);
			wvadsr_pkg::SEG_SUSTAIN: env = mul_m_q;
			default:                 env = GW'(qsh_q);
		endcase
	end

	// scale down and saturate
	assign y_sh  = (SW+3)'(yprod_q >>> FW);
	assign y_sat = (y_sh > (SW+3)'(signed'({1'b0, {(SW-1){1'b1}}}))) ?
		signed'({1'b0, {(SW-1){1'b1}}}) :
		(y_sh < (SW+3)'(signed'({1'b1, {(SW-1){1'b0}}}))) ?
		signed'({1'b1, {(SW-1){1'b0}}}) : y_sh[SW-1:0];

	// sequencer and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wvadsr_pkg::ST_IDLE;
			phase_acc_q <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (state_q == wvadsr_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				wvadsr_pkg::ST_IDLE: begin
					if (accept && wvadsr_pkg::mode_t'(mode) == wvadsr_pkg::MODE_START) begin
						phase_acc_q <= '0;
						count_q     <= '0;
					end
					if (tick) begin
						state_q <= note_done ? wvadsr_pkg::ST_FIN : wvadsr_pkg::ST_RD0;
					end
				end
				wvadsr_pkg::ST_RD0: state_q <= wvadsr_pkg::ST_RD1;
				wvadsr_pkg::ST_RD1: state_q <= wvadsr_pkg::ST_MUL;
				wvadsr_pkg::ST_MUL: begin
					state_q <= wvadsr_pkg::ST_DIV;
					step_q  <= TW'(FW);
				end
				wvadsr_pkg::ST_DIV: begin
					step_q <= step_q - TW'(1);
					if (step_q == '0) begin
						state_q <= wvadsr_pkg::ST_SCALE;
					end
				end
				wvadsr_pkg::ST_SCALE: state_q <= wvadsr_pkg::ST_FIN;
				wvadsr_pkg::ST_FIN: begin
					if (out_free) begin
						state_q     <= wvadsr_pkg::ST_IDLE;
						if (!pe_q) begin
							count_q     <= count_q + CW'(1);
							phase_acc_q <= phase_acc_q + phase_step_q;
						end
					end
				end
				default: state_q <= wvadsr_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			wvadsr_pkg::ST_IDLE: begin
				pe_q <= note_done;
				// pick the envelope segment and its ratio terms
				last_q <= (CW + 1)'(count_q) + (CW + 1)'(1) == (CW + 1)'(note_len_q);
				if (count_q < attack_len_q) begin
					seg_q   <= wvadsr_pkg::SEG_ATTACK;
					mul_m_q <= wvadsr_pkg::UNITY;
					mul_k_q <= count_q;
					den_q   <= attack_len_q;
				end else if ((CW + 1)'(count_q) <
						(CW + 1)'(attack_len_q) + (CW + 1)'(decay_len_q)) begin
					seg_q   <= wvadsr_pkg::SEG_DECAY;
					mul_m_q <= wvadsr_pkg::UNITY - sustain_q;
					mul_k_q <= count_q - attack_len_q;
					den_q   <= decay_len_q;
				end else if ((CW + 1)'(count_q) + (CW + 1)'(release_len_q) >
						(CW + 1)'(note_len_q)) begin
					seg_q   <= wvadsr_pkg::SEG_RELEASE;
					mul_m_q <= sustain_q;
					mul_k_q <= note_len_q - count_q;
					den_q   <= release_len_q;
				end else begin
					seg_q   <= wvadsr_pkg::SEG_SUSTAIN;
					mul_m_q <= sustain_q;
					mul_k_q <= '0;
					den_q   <= '0;
				end
			end
			wvadsr_pkg::ST_RD1: s0_q <= rdata_q;
			wvadsr_pkg::ST_MUL: begin
				// neighbor difference times fraction, and envelope numerator
				dprod_q <= (SW+FW+2)'((SW+1)'(rdata_q) - (SW+1)'(s0_q)) *
					(SW+FW+2)'(signed'({1'b0, phase_acc_q[PW-AW-1 -: FW]}));
				nprod_q <= NW'(mul_m_q) * NW'(mul_k_q);
			end
			wvadsr_pkg::ST_DIV: begin
				if (step_q == TW'(FW)) begin
					// quotient is below 2^16, so the top bits start as remainder
					rem_q <= RW'(nprod_q[NW-1:FW]);
					qsh_q <= nprod_q[FW-1:0];
				end else begin
					rem_q <= fits ? trial - RW'(den_q) : trial;
					qsh_q <= {qsh_q[FW-2:0], fits};
				end
				s_q <= (SW+1)'(s0_q) + (SW+1)'(dprod_q >>> FW);
			end
			wvadsr_pkg::ST_SCALE: begin
				yprod_q <= (SW+GW+2)'(s_q) * (SW+GW+2)'(signed'({1'b0, env}));
			end
			wvadsr_pkg::ST_FIN: begin
				if (out_free) begin
					audio_q    <= pe_q ? '0 : y_sat;
					last_out_q <= pe_q ? 1'b0 : last_q;
					pe_out_q   <= pe_q;
				end
			end
			default: ;
		endcase
	end

	// the divider loads its operands and then produces FW quotient bits,
	// so the quotient is complete when the sequencer reaches SCALE

	assign out_valid    = out_valid_q;
	assign audio_sample = audio_q;
	assign last_of_note = last_out_q;
	assign past_end     = pe_out_q;

	// one-hot sequencer
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state not one-hot");
	// a tick always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> state_q != wvadsr_pkg::ST_IDLE)
		else $error("tick did not start work");
	// past-end results carry no sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && past_end |-> audio_sample == '0 && !last_of_note)
		else $error("past-end result not silent");
	// voice state only moves at output load or note start
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != wvadsr_pkg::ST_FIN && state_q != wvadsr_pkg::ST_IDLE |=>
		$stable(count_q))
		else $error("sample count changed mid-tick");

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the wavetable voice: loads the table, runs notes
// under several register settings and idle patterns, and compares every
// sample item against a local model of the oscillator and envelope.
// ---------------------------------------------------------------------------
module testbench;
	import wvadsr_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_ITEMS = 137;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
		logic                          past;
	} voice_out_t;

	// voice model plus queue of samples still to arrive
	class voice_scoreboard;
		logic signed [SAMPLE_BITS-1:0] wave[TABLE_SIZE];
		logic [PHASE_BITS-1:0] phase;
		logic [COUNT_BITS-1:0] count;
		logic [PHASE_BITS-1:0] step;
		longint attack, decay, rel, note, sustain;
		voice_out_t pending_samples[$];
		int mismatches;

		function new();
			phase = '0;
			count = '0;
			step = '0;
			attack = 0;
			decay = 0;
			rel = 0;
			note = 0;
			sustain = 65536;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_BITS-1:0] data);
			case (idx)
				REG_PHASE_STEP:  step = data;
				REG_ATTACK_LEN:  attack = data[COUNT_BITS-1:0];
				REG_DECAY_LEN:   decay = data[COUNT_BITS-1:0];
				REG_RELEASE_LEN: rel = data[COUNT_BITS-1:0];
				REG_NOTE_LEN:    note = data[COUNT_BITS-1:0];
				REG_SUSTAIN: begin
					sustain = data[GAIN_BITS-1:0];
					if (sustain > 65536)
						sustain = 65536;
				end
				default: ;
			endcase
		endfunction

		function longint gain(longint n);
			if (n < attack)
				return (n * 65536) / attack;
			if (n < attack + decay)
				return 65536 - ((65536 - sustain) * (n - attack)) / decay;
			if (n + rel > note)
				return (sustain * (note - n)) / rel;
			return sustain;
		endfunction

		function void note_item(mode_t m, logic [10:0] idx, logic signed [15:0] w);
			voice_out_t o;
			logic [63:0] pos;
			logic [ADDR_BITS-1:0] i0;
			longint s0, s1, fr, s, y;
			case (m)
				MODE_WRITE: wave[idx] = w;
				MODE_START: begin
					phase = '0;
					count = '0;
				end
				MODE_TICK: begin
					if (longint'(count) >= note) begin
						o.sample = '0;
						o.last = 1'b0;
						o.past = 1'b1;
					end else begin
						pos = {32'b0, phase} << 11;
						i0 = pos[42:32];
						fr = pos[31:16];
						s0 = wave[i0];
						s1 = wave[i0 + 1'b1];
						s = s0 + (((s1 - s0) * fr) >>> 16);
						y = (s * gain(longint'(count))) >>> 16;
						if (y > 32767)
							y = 32767;
						if (y < -32768)
							y = -32768;
						o.sample = y[SAMPLE_BITS-1:0];
						o.last = (longint'(count) + 1 == note);
						o.past = 1'b0;
						count = count + 1'b1;
						phase = phase + step;
					end
					pending_samples = {pending_samples, o};
				end
				default: ;
			endcase
		endfunction

		function void check_sample(logic signed [15:0] smp, logic lst, logic pst);
			voice_out_t e;
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sample item: %0d last %0b past %0b", smp, lst, pst);
				return;
			end
			e = pending_samples.pop_front();
			if (e.sample !== smp || e.last !== lst || e.past !== pst) begin
				mismatches++;
				if (mismatches <= 10)
					$display("sample mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
						e.sample, e.last, e.past, smp, lst, pst);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] mode;
	logic [10:0] table_index;
	logic signed [SAMPLE_BITS-1:0] table_word;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_BITS-1:0] audio_sample;
	logic last_of_note;
	logic past_end;

	voice_scoreboard sb = new();
	int in_idle_pct;
	int out_idle_pct;
	int cycles;
	int ticks_sent;

	wavetable_voice_with_adsr i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .table_index(table_index), .table_word(table_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.audio_sample(audio_sample), .last_of_note(last_of_note), .past_end(past_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stall and sample check
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_sample(audio_sample, last_of_note, past_end);
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	// send one item, optionally after random idle cycles
	task automatic send_item(mode_t m, logic [10:0] idx, logic signed [15:0] w);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		table_index <= idx;
		table_word <= w;
		do @(posedge clk); while (in_stall);
		sb.note_item(m, idx, w);
		if (m == MODE_TICK)
			ticks_sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	// wait until every sample has come out and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_voice(logic [31:0] st, logic [31:0] a, logic [31:0] d,
			logic [31:0] r, logic [31:0] n, logic [31:0] s);
		write_reg(REG_PHASE_STEP, st);
		write_reg(REG_ATTACK_LEN, a);
		write_reg(REG_DECAY_LEN, d);
		write_reg(REG_RELEASE_LEN, r);
		write_reg(REG_NOTE_LEN, n);
		write_reg(REG_SUSTAIN, s);
	endtask

	// register settings per phase: extremes first, then random small notes
	task automatic choose_voice(int p);
		case (p)
			0: set_voice(32'hFFFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
				32'hFF_FFFF, 32'd0);
			1: set_voice(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536);
			2: set_voice(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd40, 32'h1_FFFF);
			3: set_voice($urandom, 32'hFF00_0003, 32'hFF00_0004, 32'hFF00_0005,
				32'hFF00_0020, 32'hFFFE_8000);
			default: set_voice($urandom, $urandom_range(0, 20), $urandom_range(0, 20),
				$urandom_range(0, 20), $urandom_range(0, 60), $urandom_range(0, 70000));
		endcase
	endtask

	// random notes: start then a run of ticks, mixed with writes and noise
	task automatic random_notes(int budget);
		int done;
		int run;
		int r;
		done = 0;
		while (done < budget) begin
			send_item(MODE_START, 11'($urandom), 16'($urandom));
			done++;
			run = $urandom_range(0, (sb.note > 60 ? 60 : int'(sb.note)) + 3);
			repeat (run) begin
				r = $urandom_range(99);
				if (r < 4)
					send_item(MODE_NONE, 11'($urandom), 16'($urandom));
				else begin
					if (r < 10)
						send_item(MODE_WRITE, 11'($urandom), 16'($urandom));
					else if (r < 13)
						send_item(MODE_START, 11'($urandom), 16'($urandom));
					else
						send_item(MODE_TICK, 11'($urandom), 16'($urandom));
					done++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_NONE;
		table_index = '0;
		table_word = '0;
		out_stall = 1'b0;
		cycles = 0;
		ticks_sent = 0;
		in_idle_pct = 0;
		out_idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick right after reset counts as past the note end
		send_item(MODE_TICK, 11'd0, 16'sd0);

		// load the whole table so no entry is read unwritten
		for (int k = 0; k < TABLE_SIZE; k++)
			send_item(MODE_WRITE, k[10:0], 16'($urandom));
		send_item(MODE_WRITE, 11'd0, 16'sh7FFF);
		send_item(MODE_WRITE, 11'd1, -16'sh8000);
		send_item(MODE_WRITE, 11'd2047, -16'sh8000);
		wait_idle();

		// directed: short note, wrap of the table, restart mid-note, unused mode
		set_voice(32'hFFFF_FFFF, 32'd2, 32'd1, 32'd2, 32'd6, 32'd40000);
		send_item(MODE_NONE, 11'h7FF, 16'shFFFF);
		send_item(MODE_START, 11'd0, 16'sd0);
		repeat (3) send_item(MODE_TICK, 11'd0, 16'sd0);
		send_item(MODE_START, 11'd0, 16'sd0);
		repeat (8) send_item(MODE_TICK, 11'h7FF, 16'sd0);
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p / 4)
				0: begin in_idle_pct = 20; out_idle_pct = 83; end
				1: begin in_idle_pct = 83; out_idle_pct = 20; end
				default: begin in_idle_pct = 0; out_idle_pct = 0; end
			endcase
			choose_voice(p);
			random_notes(PHASE_ITEMS);
			wait_idle();
		end

		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
rtl/wvadsr_pkg.sv
rtl/wavetable_voice_with_adsr.sv
test/testbench.sv
